FILE: hw/rtl/bpqt_pkg.sv
// Shared widths, codes and types for the balanced placement quota tracker.
`timescale 1ns / 1ps

package bpqt_pkg;

  localparam int DEFAULT_MAX_LOCATIONS = 16;

  localparam int TOTAL_W     = 16;  // total_items register
  localparam int COUNT_W     = 5;   // location_count register and effective count
  localparam int LOC_W       = 4;   // location field
  localparam int SLOT_W      = 17;  // per-location counter, holds quotient + 1
  localparam int MASK_OUT_W  = 16;  // reported open mask
  localparam int SPARE_OUT_W = 4;   // reported spare count
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_ITEMS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCATION_COUNT = 2'd1;

  typedef enum logic [1:0] {
    ST_OPEN   = 2'd0,
    ST_CLOSED = 2'd1,
    ST_ERROR  = 2'd2
  } status_t;

  typedef struct packed {
    status_t                 status;
    logic [MASK_OUT_W-1:0]   open_mask;
    logic [SPARE_OUT_W-1:0]  spare_left;
  } result_t;

endpackage

FILE: hw/rtl/bpqt_div.sv
// Restoring divider, one quotient bit per cycle, for the share and remainder.
`timescale 1ns / 1ps

module bpqt_div import bpqt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [TOTAL_W-1:0] dividend,
  input  logic [COUNT_W-1:0] divisor,
  output logic               busy,
  output logic               done,
  output logic [TOTAL_W-1:0] quotient,
  output logic [COUNT_W-1:0] remainder
);

  localparam int CNT_W = $clog2(TOTAL_W + 1);

  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [TOTAL_W-1:0] num_r, num_nxt;
  logic [COUNT_W-1:0] rem_r, rem_nxt;
  logic [COUNT_W-1:0] div_r, div_nxt;

  logic [COUNT_W:0]   rem_sh;
  logic [COUNT_W:0]   rem_sub;
  logic               ge;

  always_comb begin
    rem_sh  = {rem_r, num_r[TOTAL_W-1]};
    ge      = rem_sh >= {1'b0, div_r};
    rem_sub = rem_sh - {1'b0, div_r};

    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;

    if (start) begin
      cnt_nxt  = CNT_W'(TOTAL_W);
      busy_nxt = 1'b1;
      num_nxt  = dividend;
      rem_nxt  = '0;
      div_nxt  = divisor;
    end else if (busy_r) begin
      // partial remainder stays below the divisor, so it fits back in COUNT_W
      rem_nxt = ge ? rem_sub[COUNT_W-1:0] : rem_sh[COUNT_W-1:0];
      num_nxt = {num_r[TOTAL_W-2:0], ge};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign busy      = busy_r;
  assign done      = done_r;
  assign quotient  = num_r;
  assign remainder = rem_r;

endmodule

FILE: hw/rtl/bpqt_core.sv
// Per-location counters, open mask and spare count, with the single-pass update.
`timescale 1ns / 1ps

module bpqt_core import bpqt_pkg::*; #(
  parameter int MAX_LOCATIONS = DEFAULT_MAX_LOCATIONS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  logic [TOTAL_W-1:0] quot,
  input  logic [COUNT_W-1:0] rem,
  input  logic [COUNT_W-1:0] eff_n,
  input  logic               go,
  input  logic [LOC_W-1:0]   loc,
  output result_t            res
);

  localparam int MAX_CLAMP = (MAX_LOCATIONS < 31) ? MAX_LOCATIONS : 31;
  localparam int SPW       = (MAX_CLAMP > 1) ? $clog2(MAX_CLAMP) : 1;
  localparam int LIX       = (MAX_LOCATIONS > 1) ? $clog2(MAX_LOCATIONS) : 1;

  logic [SLOT_W-1:0]        slots_r   [MAX_LOCATIONS];
  logic [SLOT_W-1:0]        slots_nxt [MAX_LOCATIONS];
  logic [MAX_LOCATIONS-1:0] open_r, open_nxt;
  logic [SPW-1:0]           spare_r, spare_nxt;

  logic [LIX+LOC_W-1:0]            loc_ext;
  logic [LIX-1:0]                  idx;
  logic                            hit;
  logic                            spare_zero;
  logic [SLOT_W-1:0]               left;
  logic [MAX_LOCATIONS-1:0]        slot_one;
  logic [MAX_LOCATIONS+MASK_OUT_W-1:0] mask_ext;
  logic [SPW+SPARE_OUT_W-1:0]      spare_ext;
  logic [SLOT_W-1:0]               share;
  status_t                         status;

  always_comb begin
    // index is only used when loc < eff_n <= MAX_LOCATIONS
    loc_ext    = {{LIX{1'b0}}, loc};
    idx        = loc_ext[LIX-1:0];
    hit        = (COUNT_W'(loc) < eff_n) && open_r[idx];
    left       = slots_r[idx];
    spare_zero = (spare_r == '0);
    for (int i = 0; i < MAX_LOCATIONS; i++) begin
      slot_one[i] = (slots_r[i] == SLOT_W'(1));
    end

    slots_nxt = slots_r;
    open_nxt  = open_r;
    spare_nxt = spare_r;
    status    = ST_ERROR;

    if (hit && !(left <= SLOT_W'(1) && spare_zero)) begin
      if (left == SLOT_W'(1)) begin
        // takes a spare slot
        slots_nxt[idx] = '0;
        spare_nxt      = spare_r - SPW'(1);
        open_nxt[idx]  = 1'b0;
        if (spare_nxt == '0) begin
          open_nxt = open_nxt & ~slot_one;
        end
        status = ST_CLOSED;
      end else if (left == SLOT_W'(2) && spare_zero) begin
        slots_nxt[idx] = SLOT_W'(1);
        open_nxt[idx]  = 1'b0;
        status         = ST_CLOSED;
      end else begin
        slots_nxt[idx] = left - SLOT_W'(1);
        status         = ST_OPEN;
      end
    end

    mask_ext       = {{MASK_OUT_W{1'b0}}, open_nxt};
    spare_ext      = {{SPARE_OUT_W{1'b0}}, spare_nxt};
    res.status     = status;
    res.open_mask  = mask_ext[MASK_OUT_W-1:0];
    res.spare_left = spare_ext[SPARE_OUT_W-1:0];
  end

  assign share = {1'b0, quot} + SLOT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      // total 0 over one location: share of one, nothing spare
      for (int i = 0; i < MAX_LOCATIONS; i++) begin
        slots_r[i] <= (i == 0) ? SLOT_W'(1) : '0;
      end
      open_r  <= MAX_LOCATIONS'(1);
      spare_r <= '0;
    end else if (load) begin
      for (int i = 0; i < MAX_LOCATIONS; i++) begin
        slots_r[i] <= (i < int'(eff_n)) ? share : '0;
        open_r[i]  <= (i < int'(eff_n));
      end
      spare_r <= rem[SPW-1:0];
    end else if (go) begin
      slots_r <= slots_nxt;
      open_r  <= open_nxt;
      spare_r <= spare_nxt;
    end
  end

  a_close_clears_bit: assert property (@(posedge clk) disable iff (!rst_n)
    go && !load && status == ST_CLOSED |-> !open_nxt[idx])
    else $error("closed location still marked open");

  a_error_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    go && !load && status == ST_ERROR |=> $stable(open_r) && $stable(spare_r))
    else $error("rejected item changed state");

  a_open_ok_hit: assert property (@(posedge clk) disable iff (!rst_n)
    go && !load && status != ST_ERROR |-> hit && open_nxt != open_r || status == ST_OPEN)
    else $error("accepted item on a location that was not open");

endmodule

FILE: hw/rtl/balanced_placement_quota_tracker.sv
// Top level: config registers, share divider, input and result registers.
`timescale 1ns / 1ps

// Distributes total_items over location_count locations, floor or floor plus
// one each. Each accepted location gives one result via the input and result
// registers, and a new item can be taken every cycle while in_stall is low; a
// held result stalls the input. A write to either config register
// reinitialises all counters: the share is found by a serial divider, one
// quotient bit per cycle, while in_stall is held high. Config writes are
// only taken while no item is in flight. Reset needs no clearing pass.
module balanced_placement_quota_tracker import bpqt_pkg::*; #(
  parameter int MAX_LOCATIONS = DEFAULT_MAX_LOCATIONS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [LOC_W-1:0]       in_location,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             out_status,
  output logic [MASK_OUT_W-1:0]  out_open_mask,
  output logic [SPARE_OUT_W-1:0] out_spare_left,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int MAX_CLAMP = (MAX_LOCATIONS < 31) ? MAX_LOCATIONS : 31;

  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic               pend_r, pend_nxt;
  logic [COUNT_W-1:0] eff_n;

  logic               s1_valid_r, s1_valid_nxt;
  logic [LOC_W-1:0]   s1_loc_r;
  logic               out_valid_r, out_valid_nxt;
  result_t            out_res_r;
  result_t            core_res;

  logic               div_busy, div_done;
  logic [TOTAL_W-1:0] div_quot;
  logic [COUNT_W-1:0] div_rem;

  logic               busy;
  logic               cfg_wr;
  logic               cfg_hit;
  logic               s2_free;
  logic               s1_adv;
  logic               accept;

  assign eff_n = (count_r == '0) ? COUNT_W'(1) :
                 (count_r > COUNT_W'(MAX_CLAMP)) ? COUNT_W'(MAX_CLAMP) : count_r;

  assign busy      = pend_r | div_busy;
  assign cfg_ready = ~busy & ~s1_valid_r & ~out_valid_r;
  assign cfg_wr    = cfg_valid & cfg_ready;
  assign cfg_hit   = cfg_wr &&
                     (cfg_index == CFG_TOTAL_ITEMS || cfg_index == CFG_LOCATION_COUNT);

  assign s2_free  = ~out_valid_r | ~out_stall;
  assign s1_adv   = s1_valid_r & s2_free;
  // a config write takes the edge on its own
  assign in_stall = busy | cfg_wr | (s1_valid_r & ~s2_free);
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    total_nxt = total_r;
    count_nxt = count_r;
    if (cfg_wr) begin
      case (cfg_index)
        CFG_TOTAL_ITEMS:    total_nxt = cfg_data[TOTAL_W-1:0];
        CFG_LOCATION_COUNT: count_nxt = cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
    pend_nxt      = cfg_hit;
    s1_valid_nxt  = accept | (s1_valid_r & ~s2_free);
    out_valid_nxt = s1_adv | (out_valid_r & out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      count_r     <= COUNT_W'(1);
      pend_r      <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      total_r     <= total_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_loc_r <= in_location;
    end
    if (s1_adv) begin
      out_res_r <= core_res;
    end
  end

  // divider starts the cycle after the write, from the updated registers
  bpqt_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (pend_r),
    .dividend  (total_r),
    .divisor   (eff_n),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  bpqt_core #(
    .MAX_LOCATIONS (MAX_LOCATIONS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (div_done),
    .quot  (div_quot),
    .rem   (div_rem),
    .eff_n (eff_n),
    .go    (s1_adv),
    .loc   (s1_loc_r),
    .res   (core_res)
  );

  assign out_valid      = out_valid_r;
  assign out_status     = out_res_r.status;
  assign out_open_mask  = out_res_r.open_mask;
  assign out_spare_left = out_res_r.spare_left;

  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_hit |=> in_stall)
    else $error("input taken while counters reinitialise");

  a_adv_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid)
    else $error("item advanced but no result presented");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
    $stable(out_open_mask) && $stable(out_spare_left))
    else $error("stalled result changed");

endmodule
